### rtl/scs_pkg.sv
package scs_pkg;

    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_NONZERO = 1024;

    localparam int ROW_W  = 8;
    localparam int COL_W  = 8;
    localparam int VAL_W  = 64;
    localparam int CFG_W  = 9;
    localparam int ENT_W  = ROW_W + VAL_W;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_SRD,
        S_SCMP,
        S_SHIFT,
        S_INS,
        S_PINC,
        S_DONE
    } t_state;

endpackage

### rtl/scs_ram.sv
module scs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sparse_column_store_get_set.sv
// Sparse matrix store in compressed-sparse-column form: read, write, clear.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low (opcode, row_index, col_index, write_value). Busy stays high
// until the result has been shown.
// Result channel: o_strobe is high for exactly one cycle with o_read_value,
// o_found and o_status; the receiver cannot stall, it must take it then.
// Configuration: i_cfg_we writes i_cfg_data to num_rows (index 0) or
// num_cols (index 1) at once; write only while busy is low.
// Time from one accepted transaction to the next grows with the entries
// stepped over in the column search and, for an insert, with the entries
// moved up and the column pointers above col_index raised; out of range
// and no-op commands go straight to the result, and a clear rewrites all
// MAX_COLS + 1 column pointers. The search loop passes S_SRD and S_SCMP
// for each entry (registered RAM read); the entry shift and the pointer
// update then go one RAM step a cycle.
// Reset: a clearing pass zeroes all MAX_COLS + 1 entries of the column
// pointer RAM; busy is high during it and no result is given.
module sparse_column_store_get_set #(
    parameter int MAX_ROWS    = scs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = scs_pkg::DEF_MAX_COLS,
    parameter int MAX_NONZERO = scs_pkg::DEF_MAX_NONZERO
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [scs_pkg::ROW_W-1:0]   i_row_index,
    input  logic [scs_pkg::COL_W-1:0]   i_col_index,
    input  logic [scs_pkg::VAL_W-1:0]   i_write_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [scs_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output logic [scs_pkg::VAL_W-1:0]   o_read_value,
    output logic                        o_found,
    output logic [1:0]                  o_status
);

    import scs_pkg::*;

    localparam int AW = $clog2(MAX_NONZERO);
    localparam int CW = $clog2(MAX_NONZERO + 1);
    localparam int PW = $clog2(MAX_COLS + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_num_rows, r_num_cols;
    logic [1:0]       r_op;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_p, n_p;
    logic [CW-1:0]    r_end, n_end;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_ea, n_ea;
    logic             r_sv, n_sv, r_epend, n_epend;
    logic [PW-1:0]    r_ci, n_ci;
    logic [PW-1:0]    r_pa, n_pa;
    logic             r_pv, n_pv, r_ppend, n_ppend;
    logic             r_emit, n_emit;
    logic [VAL_W-1:0] r_rv, n_rv;
    logic             r_fnd, n_fnd;
    logic [1:0]       r_st, n_st;

    logic             accept, in_range;
    logic [ROW_W-1:0] s_row;
    logic             s_less, s_hit;

    logic             p_we, p_re;
    logic [PW-1:0]    p_waddr, p_raddr;
    logic [CW-1:0]    p_wdata, p_rdata;
    logic             e_we, e_re;
    logic [AW-1:0]    e_waddr, e_raddr;
    logic [ENT_W-1:0] e_wdata, e_rdata;

    scs_ram #(.W(CW), .D(MAX_COLS + 1)) u_ptr (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    scs_ram #(.W(ENT_W), .D(MAX_NONZERO)) u_ent (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_range = ({1'b0, i_row_index} < r_num_rows) && (32'(i_row_index) < MAX_ROWS)
                   && ({1'b0, i_col_index} < r_num_cols) && (32'(i_col_index) < MAX_COLS);

    assign s_row  = e_rdata[ENT_W-1:VAL_W];
    assign s_less = s_row < r_row;
    assign s_hit  = s_row == r_row;

    assign o_strobe     = (r_state == S_DONE);
    assign o_read_value = r_rv;
    assign o_found      = r_fnd;
    assign o_status     = r_st;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_ci == PW'(MAX_COLS)) begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_CLEAR) begin
                        n_state = S_CLR;
                    end else if ((i_opcode == OP_READ || i_opcode == OP_WRITE) && in_range) begin
                        n_state = S_P0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_P0:  n_state = S_P1;
            S_P1:  n_state = S_P2;
            S_P2:  n_state = S_P3;
            S_P3:  n_state = S_SRD;
            S_SRD: begin
                if (r_p < r_end) begin
                    n_state = S_SCMP;
                end else if (r_op == OP_READ || r_cnt >= CW'(MAX_NONZERO)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SCMP: begin
                if (s_less) begin
                    n_state = S_SRD;
                end else if (s_hit || r_op == OP_READ || r_cnt >= CW'(MAX_NONZERO)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!r_sv && !r_epend) begin
                    n_state = S_INS;
                end
            end
            S_INS: n_state = S_PINC;
            S_PINC: begin
                if (!r_pv && !r_ppend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_pa;
        p_wdata = p_rdata + 1'b1;
        p_re    = 1'b0;
        p_raddr = r_ci;
        e_we    = 1'b0;
        e_waddr = r_p[AW-1:0];
        e_wdata = {r_row, r_val};
        e_re    = 1'b0;
        e_raddr = r_p[AW-1:0];
        unique case (r_state)
            S_CLR: begin
                p_we    = 1'b1;
                p_waddr = r_ci;
                p_wdata = '0;
            end
            S_P0: begin
                p_re    = 1'b1;
                p_raddr = PW'(r_col);
            end
            S_P1: begin
                p_re    = 1'b1;
                p_raddr = PW'(r_col) + 1'b1;
            end
            S_P2: begin
                p_re    = 1'b1;
                p_raddr = PW'(MAX_COLS);
            end
            S_SRD: begin
                e_re = (r_p < r_end);
            end
            S_SCMP: begin
                e_we = s_hit && (r_op == OP_WRITE);
            end
            S_SHIFT: begin
                e_re    = r_sv;
                e_raddr = r_k;
                e_we    = r_epend;
                e_waddr = r_ea + 1'b1;
                e_wdata = e_rdata;
            end
            S_INS: begin
                e_we = 1'b1;
            end
            S_PINC: begin
                p_re = r_pv;
                p_we = r_ppend;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_p     = r_p;
        n_end   = r_end;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_ea    = r_ea;
        n_sv    = r_sv;
        n_epend = r_epend;
        n_ci    = r_ci;
        n_pa    = r_pa;
        n_pv    = r_pv;
        n_ppend = r_ppend;
        n_emit  = r_emit;
        n_rv    = r_rv;
        n_fnd   = r_fnd;
        n_st    = r_st;
        unique case (r_state)
            S_CLR: begin
                n_ci = r_ci + 1'b1;
            end
            S_IDLE: begin
                n_rv  = '0;
                n_fnd = 1'b0;
                n_st  = ST_OK;
                n_ci  = '0;
                if (accept) begin
                    n_emit = 1'b1;
                    if ((i_opcode == OP_READ || i_opcode == OP_WRITE) && !in_range) begin
                        n_st = ST_RANGE;
                    end
                end
            end
            S_P1: n_p   = p_rdata;
            S_P2: n_end = p_rdata;
            S_P3: n_cnt = p_rdata;
            S_SRD, S_SCMP: begin
                if (r_state == S_SCMP && s_less) begin
                    n_p = r_p + 1'b1;
                end else if (r_state == S_SCMP && s_hit) begin
                    n_fnd = 1'b1;
                    if (r_op == OP_READ) begin
                        n_rv = e_rdata[VAL_W-1:0];
                    end
                end else if (r_state == S_SCMP || !(r_p < r_end)) begin
                    if (r_op == OP_WRITE) begin
                        if (r_cnt >= CW'(MAX_NONZERO)) begin
                            n_st = ST_FULL;
                        end
                        n_k     = AW'(r_cnt - 1'b1);
                        n_sv    = r_cnt > r_p;
                        n_epend = 1'b0;
                    end
                end
            end
            S_SHIFT: begin
                n_epend = r_sv;
                n_ea    = r_k;
                if (r_sv) begin
                    if (r_k == r_p[AW-1:0]) begin
                        n_sv = 1'b0;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            S_INS: begin
                n_ci    = PW'(r_col) + 1'b1;
                n_pv    = 1'b1;
                n_ppend = 1'b0;
            end
            S_PINC: begin
                n_ppend = r_pv;
                n_pa    = r_ci;
                if (r_pv) begin
                    if (r_ci == PW'(MAX_COLS)) begin
                        n_pv = 1'b0;
                    end else begin
                        n_ci = r_ci + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ci       <= '0;
            r_emit     <= 1'b0;
            r_sv       <= 1'b0;
            r_epend    <= 1'b0;
            r_pv       <= 1'b0;
            r_ppend    <= 1'b0;
            r_num_rows <= CFG_RESET;
            r_num_cols <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_ci    <= n_ci;
            r_emit  <= n_emit;
            r_sv    <= n_sv;
            r_epend <= n_epend;
            r_pv    <= n_pv;
            r_ppend <= n_ppend;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_row <= i_row_index;
            r_col <= i_col_index;
            r_val <= i_write_value;
        end
        r_p   <= n_p;
        r_end <= n_end;
        r_cnt <= n_cnt;
        r_k   <= n_k;
        r_ea  <= n_ea;
        r_pa  <= n_pa;
        r_rv  <= n_rv;
        r_fnd <= n_fnd;
        r_st  <= n_st;
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scs_pkg::*;

    localparam int NCOLS = DEF_MAX_COLS;
    localparam int NNZ   = DEF_MAX_NONZERO;
    localparam int WDOG  = 200000;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
        logic [1:0]       status;
    } t_result;

    typedef struct packed {
        logic [1:0]       op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] wval;
        logic             typed;
        t_result          res;
    } t_row;

    logic i_clk, i_rst_n, start, busy;
    logic [1:0] i_opcode;
    logic [ROW_W-1:0] i_row_index;
    logic [COL_W-1:0] i_col_index;
    logic [VAL_W-1:0] i_write_value;
    logic i_cfg_we, i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic o_strobe, o_found;
    logic [VAL_W-1:0] o_read_value;
    logic [1:0] o_status;

    sparse_column_store_get_set dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    logic [CFG_W-1:0] rows_cfg, cols_cfg;
    int unsigned col_ptr[NCOLS+1];
    logic [ROW_W-1:0] ent_row[NNZ];
    logic [VAL_W-1:0] ent_val[NNZ];
    t_result pending_results[$];
    int errors, idle_cycles, send_idle_pct;

    function automatic t_result store_access(input logic [1:0] op, input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c,
                                             input logic [VAL_W-1:0] v);
        t_result res;
        int unsigned p, stop, cnt;
        res = '0;
        res.status = ST_OK;
        if (op == OP_CLEAR) begin
            foreach (col_ptr[k]) col_ptr[k] = 0;
        end else if (op == OP_READ || op == OP_WRITE) begin
            if (r >= rows_cfg || c >= cols_cfg) begin
                res.status = ST_RANGE;
            end else begin
                p = col_ptr[c];
                stop = col_ptr[c+1];
                while (p < stop && ent_row[p] < r) p++;
                if (p < stop && ent_row[p] == r) begin
                    res.found = 1'b1;
                    if (op == OP_READ) res.value = ent_val[p];
                    else ent_val[p] = v;
                end else if (op == OP_WRITE) begin
                    cnt = col_ptr[NCOLS];
                    if (cnt >= NNZ) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int unsigned k = cnt; k > p; k--) begin
                            ent_row[k] = ent_row[k-1];
                            ent_val[k] = ent_val[k-1];
                        end
                        ent_row[p] = r;
                        ent_val[p] = v;
                        for (int k = c + 1; k <= NCOLS; k++) col_ptr[k]++;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h %b %0d", $time, o_read_value, o_found,
                         o_status);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_read_value !== exp_res.value) begin
                    $display("%0t read_value exp %h got %h", $time, exp_res.value, o_read_value);
                    errors++;
                end
                if (o_found !== exp_res.found) begin
                    $display("%0t found exp %b got %b", $time, exp_res.found, o_found);
                    errors++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t status exp %0d got %0d", $time, exp_res.status, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic issue(input logic [1:0] op, input logic [ROW_W-1:0] r,
                         input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
                         input logic typed, input t_result tres);
        t_result pres;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_row_index <= r;
        i_col_index <= c;
        i_write_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pres = store_access(op, r, c, v);
        if (typed && pres !== tres) begin
            $display("%0t table row exp %h got predicted %h", $time, tres, pres);
            errors++;
        end
        pending_results.push_back(pres);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NUM_ROWS) rows_cfg = val;
        else cols_cfg = val;
        @(posedge i_clk);
    endtask

    task automatic random_items(input int n, input int rspan, input int cspan);
        logic [1:0] op;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99, 0);
            if (sel < 1) op = OP_CLEAR;
            else if (sel < 3) op = 2'd3;
            else if (sel < 55) op = OP_WRITE;
            else op = OP_READ;
            issue(op, ROW_W'($urandom_range(rspan, 0)), COL_W'($urandom_range(cspan, 0)),
                  {$urandom, $urandom}, 1'b0, '0);
        end
    endtask

    t_row stim_table[$];

    function automatic t_row mk(input logic [1:0] op, input int r, input int c,
                                input logic [VAL_W-1:0] v, input logic typed,
                                input logic [VAL_W-1:0] rv, input logic f,
                                input logic [1:0] st);
        t_row t;
        t.op = op; t.row = ROW_W'(r); t.col = COL_W'(c); t.wval = v; t.typed = typed;
        t.res.value = rv; t.res.found = f; t.res.status = st;
        return t;
    endfunction

    initial begin
        logic [VAL_W-1:0] ones;
        ones = '1;
        start = 1'b0; i_opcode = OP_READ; i_row_index = '0; i_col_index = '0;
        i_write_value = '0; i_cfg_we = 1'b0; i_cfg_index = CFG_NUM_ROWS; i_cfg_data = '0;
        errors = 0; send_idle_pct = 0;
        rows_cfg = CFG_RESET; cols_cfg = CFG_RESET;
        foreach (col_ptr[k]) col_ptr[k] = 0;
        foreach (ent_row[k]) begin ent_row[k] = '0; ent_val[k] = '0; end
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stim_table.push_back(mk(OP_READ, 0, 0, 0, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 255, 255, 0, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 255, 255, ones, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 255, 255, 0, 1, ones, 1, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 0, 0, 64'h0123456789abcdef, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 5, 0, 64'h5555, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 2, 0, 64'h2222, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 2, 0, 64'haaaa, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 2, 0, ones, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 3, 0, 0, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_WRITE, 7, 128, 64'h8000000000000000, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 7, 128, 0, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, ST_OK));
        stim_table.push_back(mk(2'd3, 9, 9, ones, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_CLEAR, 0, 0, 0, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 255, 255, 0, 1, 0, 0, ST_OK));
        stim_table.push_back(mk(OP_READ, 0, 0, 0, 1, 0, 0, ST_OK));
        foreach (stim_table[i])
            issue(stim_table[i].op, stim_table[i].row, stim_table[i].col, stim_table[i].wval,
                  stim_table[i].typed, stim_table[i].res);
        drain();

        set_cfg(CFG_NUM_ROWS, 9'd1);
        set_cfg(CFG_NUM_COLS, 9'd1);
        issue(OP_WRITE, 1, 0, 1, 1'b1, '{value: 0, found: 0, status: ST_RANGE});
        issue(OP_READ, 0, 1, 0, 1'b1, '{value: 0, found: 0, status: ST_RANGE});
        issue(OP_WRITE, 0, 0, 64'h77, 1'b0, '0);
        drain();
        set_cfg(CFG_NUM_ROWS, 9'd0);
        issue(OP_READ, 0, 0, 0, 1'b1, '{value: 0, found: 0, status: ST_RANGE});
        drain();
        set_cfg(CFG_NUM_ROWS, 9'd511);
        set_cfg(CFG_NUM_COLS, 9'd511);
        issue(OP_READ, 0, 0, 0, 1'b0, '0);
        drain();

        // phases: small ranges for hits, then mixed ranges
        set_cfg(CFG_NUM_ROWS, 9'd8);
        set_cfg(CFG_NUM_COLS, 9'd6);
        send_idle_pct = 0;
        random_items(90, 10, 7);
        drain();
        set_cfg(CFG_NUM_ROWS, 9'd256);
        set_cfg(CFG_NUM_COLS, 9'd256);
        send_idle_pct = 76;
        random_items(90, 255, 255);
        drain();
        set_cfg(CFG_NUM_ROWS, 9'd40);
        set_cfg(CFG_NUM_COLS, 9'd3);
        send_idle_pct = 7;
        random_items(100, 45, 4);
        drain();
        set_cfg(CFG_NUM_ROWS, 9'd256);
        set_cfg(CFG_NUM_COLS, 9'd16);
        send_idle_pct = 0;
        random_items(80, 255, 20);
        drain();

        set_cfg(CFG_NUM_COLS, 9'd256);
        issue(OP_CLEAR, 0, 0, 0, 1'b0, '0);
        send_idle_pct = 76;
        random_items(80, 255, 255);
        drain();

        if (errors == 0 && pending_results.size() == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule
